@@ rtl/file_region_lock_table_unit_assert.svh @@
// Assertion macros for the region lock table unit.
`ifndef FILE_REGION_LOCK_TABLE_UNIT_ASSERT_SVH
`define FILE_REGION_LOCK_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define FRLT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define FRLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/frlt_pkg.sv @@
// Package: commands, sequencer states, shared types and defaults of the lock table.
package frlt_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int CLUSTER_BITS_DEF  = 32;

	typedef enum logic [2:0] {
		CMD_LOCK       = 3'd0,
		CMD_UNLOCK     = 3'd1,
		CMD_IO_CHECK   = 3'd2,
		CMD_FILE_CLOSE = 3'd3,
		CMD_OWNER_CLOSE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic scan;
		logic fin;
	} ctl_t;

	typedef struct packed {
		logic file_eq;
		logic owner_eq;
		logic exact;
		logic overlap;
	} match_t;

endpackage

@@ rtl/frlt_match.sv @@
// Shared compare unit: matches one table entry against the held request.
module frlt_match import frlt_pkg::*; #(
	parameter int CLUSTER_BITS = CLUSTER_BITS_DEF
) (
	input  logic [7:0]              e_drive,
	input  logic [CLUSTER_BITS-1:0] e_cluster,
	input  logic [15:0]             e_slot,
	input  logic [15:0]             e_owner,
	input  logic [31:0]             e_start,
	input  logic [31:0]             e_len,
	input  logic [7:0]              r_drive,
	input  logic [CLUSTER_BITS-1:0] r_cluster,
	input  logic [15:0]             r_slot,
	input  logic [15:0]             r_owner,
	input  logic [31:0]             r_start,
	input  logic [31:0]             r_len,
	input  logic [31:0]             r_end,
	output match_t                  m
);

	logic [31:0] e_end;

	assign e_end = e_start + e_len;

	always_comb begin
		m.file_eq  = (e_drive == r_drive) && (e_cluster == r_cluster) && (e_slot == r_slot);
		m.owner_eq = (e_owner == r_owner);
		m.exact    = (e_start == r_start) && (e_len == r_len);
		m.overlap  = (e_start < r_end) && (r_start < e_end);
	end

endmodule

@@ rtl/frlt_ctrl.sv @@
// Sequencer: walks the table index once per request and flags the final step.
module frlt_ctrl import frlt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output ctl_t          ctl,
	output logic [IW-1:0] rd_idx
);

	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	state_t        state_q, state_nxt;
	logic [IW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + IW'(1);
			end else begin
				idx_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_nxt = ST_SCAN;
			ST_SCAN:  if (idx_q == LAST_IDX) state_nxt = ST_DRAIN;
			ST_DRAIN: state_nxt = ST_FIN;
			ST_FIN:   state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		ctl.scan = 1'b0;
		ctl.fin  = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_SCAN:  ctl.scan = 1'b1;
			ST_DRAIN: ;
			ST_FIN:   ctl.fin = 1'b1;
			default:  busy = 1'b0;
		endcase
	end

	assign rd_idx = idx_q;

endmodule

@@ rtl/file_region_lock_table_unit.sv @@
// Top level: byte-range lock table with entry memory, valid bits and result register.
// A request passes the scan, drain and finish states before the registered done strobe.
// A new request is taken only while busy is low; busy stays high while the table is walked.
// The walk reads one entry per cycle from the entry memory through one compare unit.
// done stands for one cycle and status holds until the next result; the receiver cannot stall them.
// Reset clears all valid bits and the sequencer at once; no clearing pass is needed.
`include "file_region_lock_table_unit_assert.svh"

module file_region_lock_table_unit import frlt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int CLUSTER_BITS  = CLUSTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [7:0]  drive,
	input  logic [31:0] parent_cluster,
	input  logic [15:0] dir_slot,
	input  logic [15:0] owner,
	input  logic [31:0] region_start,
	input  logic [31:0] region_length,
	output logic        done,
	output logic        status
);

	localparam int IW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ENTRY_W = 8 + CLUSTER_BITS + 16 + 16 + 32 + 32;

	ctl_t          ctl;
	logic [IW-1:0] rd_idx;
	logic          accept;

	logic [2:0]              cmd_q;
	logic [7:0]              drive_q;
	logic [CLUSTER_BITS-1:0] cluster_q;
	logic [15:0]             slot_q;
	logic [15:0]             owner_q;
	logic [31:0]             start_q;
	logic [31:0]             len_q;
	logic [31:0]             end_q;
	logic                    len_zero;

	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] rd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic [7:0]              e_drive;
	logic [CLUSTER_BITS-1:0] e_cluster;
	logic [15:0]             e_slot;
	logic [15:0]             e_owner;
	logic [31:0]             e_start;
	logic [31:0]             e_len;
	match_t                  m;

	logic          viol_q;
	logic          hit_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic          ev;
	logic          clr;
	logic          fin_status;
	logic          do_write;
	logic          done_q;
	logic          status_q;

	frlt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.rd_idx (rd_idx)
	);

	assign accept   = start && !busy;
	assign len_zero = (len_q == 32'd0);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			drive_q   <= drive;
			cluster_q <= parent_cluster[CLUSTER_BITS-1:0];
			slot_q    <= dir_slot;
			owner_q   <= owner;
			start_q   <= region_start;
			len_q     <= region_length;
			end_q     <= region_start + region_length;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[free_idx_q] <= {drive_q, cluster_q, slot_q, owner_q, start_q, len_q};
		end
		rd_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.scan;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
	end

	assign {e_drive, e_cluster, e_slot, e_owner, e_start, e_len} = rd_q;

	frlt_match #(
		.CLUSTER_BITS(CLUSTER_BITS)
	) u_match (
		.e_drive   (e_drive),
		.e_cluster (e_cluster),
		.e_slot    (e_slot),
		.e_owner   (e_owner),
		.e_start   (e_start),
		.e_len     (e_len),
		.r_drive   (drive_q),
		.r_cluster (cluster_q),
		.r_slot    (slot_q),
		.r_owner   (owner_q),
		.r_start   (start_q),
		.r_len     (len_q),
		.r_end     (end_q),
		.m         (m)
	);

	assign ev = vld_s1 && valid_q[idx_s1];

	always_comb begin
		clr = 1'b0;
		case (cmd_q)
			CMD_UNLOCK:      clr = ev && !hit_q && m.file_eq && m.owner_eq && m.exact;
			CMD_FILE_CLOSE:  clr = ev && m.file_eq;
			CMD_OWNER_CLOSE: clr = ev && m.owner_eq;
			default:         clr = 1'b0;
		endcase
	end

	always_comb begin
		fin_status = 1'b1;
		case (cmd_q) inside
			CMD_LOCK:        fin_status = !len_zero && (viol_q || !free_q);
			CMD_UNLOCK:      fin_status = !hit_q;
			CMD_IO_CHECK:    fin_status = viol_q;
			CMD_FILE_CLOSE,
			CMD_OWNER_CLOSE: fin_status = 1'b0;
			default:         fin_status = 1'b1;
		endcase
	end

	assign do_write = ctl.fin && (cmd_q == CMD_LOCK) && !len_zero && !viol_q && free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_write) begin
			valid_q[free_idx_q] <= 1'b1;
		end else if (clr) begin
			valid_q[idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viol_q     <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else if (accept) begin
			viol_q <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (vld_s1) begin
			if (cmd_q == CMD_LOCK && !valid_q[idx_s1]) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (ev && !len_zero && m.file_eq && m.overlap) begin
				if (cmd_q == CMD_LOCK || (cmd_q == CMD_IO_CHECK && !m.owner_eq)) begin
					viol_q <= 1'b1;
				end
			end
			if (clr && cmd_q == CMD_UNLOCK) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
			if (ctl.fin) begin
				status_q <= fin_status;
			end
		end
	end

	assign done   = done_q;
	assign status = status_q;

	`FRLT_ASSERT_NEXT(a_accept_busy, accept, busy, "request accepted but unit not busy")
	`FRLT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still walking the table")
	`FRLT_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")
	`FRLT_ASSERT_NOW(a_write_no_clear, do_write, !vld_s1, "entry write overlaps the table walk")

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for the region lock table: predicts every status and compares on done.
module testbench import frlt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
	localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
	localparam int         RANDOM_REQUESTS = 2000;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  drive;
		logic [31:0] cluster;
		logic [15:0] slot;
		logic [15:0] owner;
		logic [31:0] offset;
		logic [31:0] length;
	} lock_req_t;

	class lock_status_board;
		bit        held[TABLE_ENTRIES_DEF];
		lock_req_t ent[TABLE_ENTRIES_DEF];
		bit        status_due[$];
		int        mismatches;

		function new();
			mismatches = 0;
			foreach (held[e]) held[e] = 1'b0;
		endfunction

		function bit file_key_eq(int e, lock_req_t r);
			return ent[e].drive == r.drive && ent[e].cluster == r.cluster &&
				ent[e].slot == r.slot;
		endfunction

		function bit overlaps(logic [31:0] s1, logic [31:0] l1, logic [31:0] s2,
				logic [31:0] l2);
			logic [31:0] e1;
			logic [31:0] e2;
			e1 = s1 + l1;
			e2 = s2 + l2;
			return s1 < e2 && s2 < e1;
		endfunction

		function bit predict_status(lock_req_t r);
			bit st;
			int free_e;
			st = 1'b0;
			free_e = -1;
			case (r.op)
				CMD_LOCK: begin
					if (r.length != 0) begin
						for (int e = 0; e < TABLE_ENTRIES_DEF; e++) begin
							if (!held[e])
								free_e = e;
							else if (file_key_eq(e, r) &&
									overlaps(ent[e].offset, ent[e].length, r.offset, r.length))
								st = 1'b1;
						end
						if (!st && free_e < 0)
							st = 1'b1;
						if (!st) begin
							held[free_e] = 1'b1;
							ent[free_e] = r;
						end
					end
				end
				CMD_UNLOCK: begin
					st = 1'b1;
					for (int e = 0; e < TABLE_ENTRIES_DEF; e++) begin
						if (st && held[e] && ent[e].owner == r.owner && file_key_eq(e, r) &&
								ent[e].offset == r.offset && ent[e].length == r.length) begin
							held[e] = 1'b0;
							st = 1'b0;
						end
					end
				end
				CMD_IO_CHECK: begin
					if (r.length != 0)
						for (int e = 0; e < TABLE_ENTRIES_DEF; e++)
							if (held[e] && ent[e].owner != r.owner && file_key_eq(e, r) &&
									overlaps(ent[e].offset, ent[e].length, r.offset, r.length))
								st = 1'b1;
				end
				CMD_FILE_CLOSE: begin
					for (int e = 0; e < TABLE_ENTRIES_DEF; e++)
						if (held[e] && file_key_eq(e, r))
							held[e] = 1'b0;
				end
				CMD_OWNER_CLOSE: begin
					for (int e = 0; e < TABLE_ENTRIES_DEF; e++)
						if (held[e] && ent[e].owner == r.owner)
							held[e] = 1'b0;
				end
				default: st = 1'b1;
			endcase
			return st;
		endfunction

		function void note_request(lock_req_t r);
			status_due.push_back(predict_status(r));
		endfunction

		function void check_status(logic got);
			bit want;
			if (status_due.size() == 0) begin
				$display("%0t: unexpected done, expected nothing, actual status %0b", $time, got);
				mismatches++;
			end else begin
				want = status_due.pop_front();
				if (got !== want) begin
					$display("%0t: status mismatch, expected %0b, actual %0b", $time, want, got);
					mismatches++;
				end
			end
		endfunction

		function void report_leftovers();
			foreach (status_due[i]) begin
				$display("%0t: status never came, expected %0b, actual none", $time,
					status_due[i]);
				mismatches++;
			end
		endfunction

		function int held_count();
			int n;
			n = 0;
			foreach (held[e]) n += int'(held[e]);
			return n;
		endfunction

		function int pick_held();
			int idx[$];
			foreach (held[e]) if (held[e]) idx.push_back(e);
			if (idx.size() == 0)
				return -1;
			return idx[$urandom_range(0, idx.size() - 1)];
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  cmd = CMD_LOCK;
	logic [7:0]  drive = '0;
	logic [31:0] parent_cluster = '0;
	logic [15:0] dir_slot = '0;
	logic [15:0] owner = '0;
	logic [31:0] region_start = '0;
	logic [31:0] region_length = '0;
	logic        done;
	logic        status;

	lock_status_board board;
	lock_req_t        files[8];
	logic [15:0]      owners[4];

	file_region_lock_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.drive(drive),
		.parent_cluster(parent_cluster),
		.dir_slot(dir_slot),
		.owner(owner),
		.region_start(region_start),
		.region_length(region_length),
		.done(done),
		.status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("** file_region_lock_table_unit: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_status(status);
	end

	function automatic lock_req_t mk(logic [2:0] op, int fi, logic [15:0] own,
			logic [31:0] off, logic [31:0] len);
		lock_req_t r;
		r = files[fi];
		r.op = op;
		r.owner = own;
		r.offset = off;
		r.length = len;
		return r;
	endfunction

	function automatic lock_req_t shape_region(lock_req_t r);
		case ($urandom_range(0, 9))
			0: begin
				r.offset = $urandom;
				r.length = '0;
			end
			1: begin
				r.offset = 32'hFFFF_FF00 + $urandom_range(0, 255);
				r.length = $urandom_range(1, 512);
			end
			2: begin
				r.offset = $urandom;
				r.length = $urandom;
			end
			default: begin
				r.offset = $urandom_range(0, 2047);
				r.length = $urandom_range(1, 96);
			end
		endcase
		return r;
	endfunction

	function automatic lock_req_t random_request();
		lock_req_t r;
		int pick;
		int e;
		pick = $urandom_range(0, 99);
		e = board.pick_held();
		r = shape_region(mk(CMD_LOCK, $urandom_range(0, 7), owners[$urandom_range(0, 3)], 0, 0));
		if (pick < 45) begin
			r.op = CMD_LOCK;
		end else if (pick < 60) begin
			r.op = CMD_UNLOCK;
			if (e >= 0 && $urandom_range(0, 3) != 0) begin
				r = board.ent[e];
				r.op = CMD_UNLOCK;
			end
		end else if (pick < 80) begin
			r.op = CMD_IO_CHECK;
			if (e >= 0 && $urandom_range(0, 1) != 0) begin
				r.drive = board.ent[e].drive;
				r.cluster = board.ent[e].cluster;
				r.slot = board.ent[e].slot;
				r.offset = board.ent[e].offset + $urandom_range(0, 15);
			end
		end else if (pick < 84) begin
			r.op = CMD_FILE_CLOSE;
			if (e >= 0) begin
				r.drive = board.ent[e].drive;
				r.cluster = board.ent[e].cluster;
				r.slot = board.ent[e].slot;
			end
		end else if (pick < 88) begin
			r.op = CMD_OWNER_CLOSE;
		end else if (pick < 91) begin
			r.op = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
		end else begin
			r.op = 3'($urandom_range(0, 7));
			r.drive = 8'($urandom);
			r.cluster = $urandom;
			r.slot = 16'($urandom);
			r.owner = 16'($urandom);
			r.offset = $urandom;
			r.length = $urandom;
		end
		return r;
	endfunction

	task automatic send_request(lock_req_t r);
		@(negedge clk);
		cmd <= r.op;
		drive <= r.drive;
		parent_cluster <= r.cluster;
		dir_slot <= r.slot;
		owner <= r.owner;
		region_start <= r.offset;
		region_length <= r.length;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		board.note_request(r);
	endtask

	task automatic issue(lock_req_t r, bit may_idle);
		send_request(r);
		if (may_idle && $urandom_range(0, 99) < 38) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 44)) @(negedge clk);
		end
	endtask

	task automatic fill_table();
		int guard;
		guard = 0;
		while (board.held_count() < TABLE_ENTRIES_DEF && guard < 200) begin
			issue(mk(CMD_LOCK, $urandom_range(0, 7), owners[$urandom_range(0, 3)], $urandom,
				$urandom_range(1, 16)), 1'b1);
			guard++;
		end
		repeat (2)
			issue(mk(CMD_LOCK, $urandom_range(0, 7), owners[$urandom_range(0, 3)], $urandom,
				$urandom_range(1, 16)), 1'b1);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (board.status_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		board = new;
		files[0] = '0;
		files[0].drive = 8'($urandom);
		files[0].cluster = $urandom;
		files[0].slot = 16'($urandom);
		files[1] = files[0];
		files[1].slot = files[0].slot + 16'd1;
		files[2] = files[0];
		files[2].drive = files[0].drive ^ 8'h01;
		files[3] = files[0];
		files[3].cluster = files[0].cluster ^ 32'h8000_0000;
		files[4] = '1;
		files[5] = '0;
		for (int i = 6; i < 8; i++) begin
			files[i] = '0;
			files[i].drive = 8'($urandom);
			files[i].cluster = $urandom;
			files[i].slot = 16'($urandom);
		end
		owners[0] = '0;
		owners[1] = 16'($urandom_range(1, 16'h7FFF));
		owners[2] = owners[1] + 16'd1;
		owners[3] = '1;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		issue(mk(CMD_LOCK, 0, owners[1], 100, 0), 1'b1);
		issue(mk(CMD_LOCK, 0, owners[1], 100, 50), 1'b1);
		issue(mk(CMD_LOCK, 0, owners[2], 120, 10), 1'b1);
		issue(mk(CMD_LOCK, 0, owners[1], 140, 20), 1'b1);
		issue(mk(CMD_LOCK, 0, owners[1], 150, 10), 1'b1);
		issue(mk(CMD_LOCK, 1, owners[2], 100, 50), 1'b1);
		issue(mk(CMD_IO_CHECK, 0, owners[2], 110, 5), 1'b1);
		issue(mk(CMD_IO_CHECK, 0, owners[1], 110, 5), 1'b1);
		issue(mk(CMD_IO_CHECK, 0, owners[2], 110, 0), 1'b1);
		issue(mk(CMD_UNLOCK, 0, owners[1], 100, 49), 1'b1);
		issue(mk(CMD_UNLOCK, 0, owners[2], 100, 50), 1'b1);
		issue(mk(CMD_UNLOCK, 0, owners[1], 100, 0), 1'b1);
		issue(mk(CMD_UNLOCK, 0, owners[1], 100, 50), 1'b1);
		issue(mk(CMD_LOCK, 4, owners[3], 32'hFFFF_FFF0, 32), 1'b1);
		issue(mk(CMD_LOCK, 4, owners[0], 0, 8), 1'b1);
		issue(mk(CMD_IO_CHECK, 4, owners[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1);
		issue(mk(CMD_LOCK, 5, owners[0], 0, 32'hFFFF_FFFF), 1'b1);
		issue(mk(CMD_IO_CHECK, 5, owners[3], 32'h8000_0000, 1), 1'b1);
		issue(mk(CMD_FILE_CLOSE, 4, owners[2], 0, 0), 1'b1);
		issue(mk(CMD_OWNER_CLOSE, 2, owners[1], 0, 0), 1'b1);
		for (int op = CMD_UNDEF_LO; op <= CMD_UNDEF_HI; op++)
			issue(mk(3'(op), 0, owners[1], 100, 50), 1'b1);
		issue(mk(CMD_FILE_CLOSE, 0, owners[0], 0, 0), 1'b1);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 300 == 150)
				fill_table();
			if (n == 1000)
				drain();
			issue(random_request(), !(n >= 600 && n < 900));
		end

		drain();
		repeat (40) @(posedge clk);
		board.report_leftovers();
		if (board.mismatches == 0)
			$display("** file_region_lock_table_unit: PASSED **");
		else
			$display("** file_region_lock_table_unit: FAILED **");
		$finish;
	end
endmodule

@@ file_region_lock_table_unit.f @@
+incdir+rtl
rtl/frlt_pkg.sv
rtl/frlt_match.sv
rtl/frlt_ctrl.sv
rtl/file_region_lock_table_unit.sv
dv/testbench.sv
